// File: sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and codes for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pfe_pkg;

    localparam int WORD_W    = 32;
    localparam int OPERAND_W = 31;
    localparam int CMD_W     = 3;
    localparam int ERR_W     = 2;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CMD_W-1:0]  cmd_t;

    // token kinds; codes above CMD_DIV are ignored
    localparam cmd_t CMD_PUSH = 3'd0;
    localparam cmd_t CMD_ADD  = 3'd1;
    localparam cmd_t CMD_SUB  = 3'd2;
    localparam cmd_t CMD_MUL  = 3'd3;
    localparam cmd_t CMD_DIV  = 3'd4;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDERFLOW = 2'd1,
        ERR_DIVZERO   = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

endpackage

// File: sv/pfe_token_if.sv
// ----------------------------------------------------------------------------
// pfe_token_if
// Token channel: one parsed postfix token per beat.
// ----------------------------------------------------------------------------
interface pfe_token_if import pfe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    cmd_t                 command;
    logic [OPERAND_W-1:0] operand;
    logic                 last;

    modport source (output valid, output command, output operand, output last, input ready);
    modport sink   (input valid, input command, input operand, input last, output ready);
endinterface

// File: sv/pfe_result_if.sv
// ----------------------------------------------------------------------------
// pfe_result_if
// Result channel: answer and first error, one beat per expression.
// ----------------------------------------------------------------------------
interface pfe_result_if import pfe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [WORD_W-1:0] answer;
    logic [ERR_W-1:0]   error;

    modport source (output valid, output answer, output error, input ready);
    modport sink   (input valid, input answer, input error, output ready);
endinterface

// File: sv/postfix_stack_evaluator_core.sv
// Flow: a push completes on acceptance; add/sub pass through the execute state, multiply
// through the execute and multiply states, divide through execute and the serial divider
// (one quotient bit per cycle). No token is taken until an operator finishes; a zero
// divisor skips the divider and finishes like add/sub. The stack RAM read is registered.
// A last token then passes the emit state, which waits while the result beat stalls.
// Reset (rst_n, async, low) empties the stack and clears the sticky error; RAM not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Postfix evaluator: cached top of stack in a register, the rest in a RAM.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_core
    import pfe_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    pfe_token_if.sink     token,
    pfe_result_if.source  result
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    err_t            err_reg, err_next;
    word_t           top_reg, top_next;
    cmd_t            cmd_reg, cmd_next;
    logic            last_reg, last_next;
    word_t           prod_reg, prod_next;
    logic            out_valid_reg, out_valid_next;
    word_t           answer_reg, answer_next;
    err_t            error_reg, error_next;

    logic            ram_we;
    logic [CW-1:0]   wr_index;
    logic [CW-1:0]   rd_index;
    word_t           left;
    div_req_t        div_req;
    logic            div_done;
    word_t           div_q;
    state_t          done_state;

    assign wr_index = count_reg - 1'b1;
    assign rd_index = count_reg - CW'(2);

    pfe_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_index[AW-1:0]),
        .wdata (top_reg),
        .raddr (rd_index[AW-1:0]),
        .rdata (left)
    );

    pfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        err_next         = err_reg;
        top_next         = top_reg;
        cmd_next         = cmd_reg;
        last_next        = last_reg;
        prod_next        = prod_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        answer_next      = answer_reg;
        error_next       = error_reg;
        ram_we           = 1'b0;
        token.ready      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = left;
        div_req.divisor  = top_reg;
        done_state       = last_reg ? ST_EMIT : ST_IDLE;

        unique case (state_reg)
            ST_IDLE:
            begin
                token.ready = 1'b1;
                // ready is high throughout this state, so valid alone marks a beat
                if (token.valid)
                begin
                    cmd_next   = token.command;
                    last_next  = token.last;
                    state_next = token.last ? ST_EMIT : ST_IDLE;
                    if (token.command == CMD_PUSH)
                    begin
                        if (count_reg < CW'(STACK_DEPTH))
                        begin
                            // old top spills into the RAM
                            ram_we     = (count_reg != '0);
                            top_next   = {1'b0, token.operand};
                            count_next = count_reg + 1'b1;
                        end
                        else if (err_reg == ERR_NONE)
                        begin
                            err_next = ERR_OVERFLOW;
                        end
                    end
                    else if (token.command <= CMD_DIV)
                    begin
                        if (count_reg < CW'(2))
                        begin
                            if (err_reg == ERR_NONE)
                            begin
                                err_next = ERR_UNDERFLOW;
                            end
                        end
                        else
                        begin
                            state_next = ST_EXEC;
                        end
                    end
                end
            end

            ST_EXEC:
            begin
                priority if (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB)
                begin
                    top_next   = (cmd_reg == CMD_ADD) ? (left + top_reg) : (left - top_reg);
                    count_next = count_reg - 1'b1;
                    state_next = done_state;
                end
                else if (cmd_reg == CMD_MUL)
                begin
                    prod_next  = left * top_reg;
                    state_next = ST_MUL;
                end
                else if (top_reg == '0)
                begin
                    top_next   = '0;
                    count_next = count_reg - 1'b1;
                    if (err_reg == ERR_NONE)
                    begin
                        err_next = ERR_DIVZERO;
                    end
                    state_next = done_state;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end

            ST_MUL:
            begin
                top_next   = prod_reg;
                count_next = count_reg - 1'b1;
                state_next = done_state;
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    top_next   = div_q;
                    count_next = count_reg - 1'b1;
                    state_next = done_state;
                end
            end

            ST_EMIT:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    answer_next    = (count_reg != '0) ? top_reg : '0;
                    error_next     = (count_reg == '0 && err_reg == ERR_NONE)
                                     ? ERR_UNDERFLOW : err_reg;
                    count_next     = '0;
                    err_next       = ERR_NONE;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        cmd_reg    <= cmd_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        answer_reg <= answer_next;
        error_reg  <= error_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.answer = answer_reg;
    assign result.error  = error_reg;

endmodule

// File: sv/pfe_stack_ram.sv
// ----------------------------------------------------------------------------
// pfe_stack_ram
// Stack body below the cached top: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfe_stack_ram
    import pfe_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  word_t                    wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output word_t                    rdata
);

    word_t mem [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/pfe_div.sv
// ----------------------------------------------------------------------------
// pfe_div
// Signed divider truncating toward zero, restoring, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pfe_div
    import pfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output logic     done,
    output word_t    quotient
);

    word_t        rem_reg, rem_next;
    word_t        quo_reg, quo_next;
    word_t        dvs_reg, dvs_next;
    logic         neg_reg, neg_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [WORD_W:0] shifted;
    logic [WORD_W:0] diff;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};

        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend[WORD_W-1] ? (~req.dividend + 1'b1) : req.dividend;
            dvs_next  = req.divisor[WORD_W-1] ? (~req.divisor + 1'b1) : req.divisor;
            neg_next  = req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                rem_next = diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    // most negative by minus one wraps back to itself here
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// File: sv/pfe_checker.sv
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks on the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker
    import pfe_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 tok_valid,
    input logic                 tok_ready,
    input cmd_t                 tok_command,
    input logic                 tok_last,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [WORD_W-1:0]    res_answer,
    input logic [ERR_W-1:0]     res_error
);

    logic tok_beat;

    assign tok_beat = tok_valid && tok_ready;

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_answer) && $stable(res_error))
        else $error("result beat changed while stalled");

    // the final token always takes the block out of the accepting state
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_beat && tok_last |=> !tok_ready)
        else $error("token accepted straight after a last beat");

    // pushes and ignored codes leave the input ready again in the next cycle
    a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
        tok_beat && !tok_last && (tok_command == CMD_PUSH || tok_command > CMD_DIV)
        |=> tok_ready)
        else $error("single-cycle token did not free the input");

    // a new result is only loaded while no token can be taken
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!tok_ready))
        else $error("result appeared while idle");

endmodule

bind postfix_stack_evaluator_core pfe_checker u_pfe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (token.valid),
    .tok_ready   (token.ready),
    .tok_command (token.command),
    .tok_last    (token.last),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_answer  (result.answer),
    .res_error   (result.error)
);
